### hdl/salc_pkg.sv
// shared types and constants of the set-associative lru cache lookup
package salc_pkg;

  // fixed field widths
  localparam int ADDR_W     = 48;
  localparam int OP_W       = 2;
  localparam int OUTCOME_W  = 2;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SET_BITS_W = 3;
  localparam int OFFSET_W   = 5;
  localparam int WAYS_CFG_W = 4;

  localparam int OUT_FIELDS_W = OUTCOME_W + 3 * CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // default build
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_TAG_WIDTH    = 32;

  // access kinds
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  // result outcomes
  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic load_in;  // capture the accepted beat
    logic rd_en;    // read the set row
    logic commit;   // write the row back and load the result register
    logic last;     // result closes the access
  } salc_cmd_t;

  typedef struct packed {
    logic modify;   // captured access is a modify
    logic out_free; // result register can take a result this cycle
  } salc_stat_t;

endpackage

### hdl/salc_ram.sv
// generic single-write, single-read ram with registered read data
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/salc_ctrl.sv
// sequencer: accept, read set row, look up and write back, once or twice per access
module salc_ctrl import salc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  salc_stat_t stat,
  output salc_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       pass;
  logic       pass_next;

  always_comb begin
    state_next  = state;
    pass_next   = pass;
    s_tready    = 1'b0;
    cmd         = '0;
    // a modify runs a second lookup after the first
    cmd.last    = !(stat.modify && !pass);
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          pass_next   = 1'b0;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          if (stat.modify && !pass) begin
            pass_next  = 1'b1;
            state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

endmodule

### hdl/salc_dp.sv
// datapath: config registers, address split, set row store, lru update, totals, result register
module salc_dp import salc_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int TAG_WIDTH    = DEF_TAG_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]     s_tdata,
  input  logic [OP_W-1:0]       s_tuser,
  input  salc_cmd_t             cmd,
  output salc_stat_t            stat,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int SW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 2 ** MAX_SET_BITS;
  localparam int MW       = MAX_WAYS;
  localparam int WW       = (MW > 1) ? $clog2(MW) : 1;
  localparam int RW       = (MW > 1) ? $clog2(MW) : 1;
  localparam int XW       = (TAG_WIDTH > ADDR_W) ? TAG_WIDTH : ADDR_W;
  localparam int REC_OFS  = MW;
  localparam int TAG_OFS  = MW + MW * RW;
  localparam int ROW_W    = TAG_OFS + MW * TAG_WIDTH;
  localparam logic [RW-1:0] REC_MAX = RW'(MW - 1);

  // configuration
  logic [SET_BITS_W-1:0] set_bits;
  logic [OFFSET_W-1:0]   offset_bits;
  logic [WAYS_CFG_W-1:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      offset_bits <= '0;
      ways_in_use <= WAYS_CFG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SET_BITS:    set_bits    <= cfg_data[SET_BITS_W-1:0];
        CFG_OFFSET_BITS: offset_bits <= cfg_data[OFFSET_W-1:0];
        CFG_WAYS:        ways_in_use <= cfg_data[WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [3:0]        eff_sb;
  logic [5:0]        tag_shamt;
  logic [ADDR_W-1:0] addr_shifted;
  logic [XW-1:0]     tag_shifted;
  logic [SW-1:0]     set_mask;
  logic [SW-1:0]     set_in;

  always_comb begin
    eff_sb = (4'(set_bits) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(set_bits);
    tag_shamt    = 6'(eff_sb) + 6'(offset_bits);
    addr_shifted = s_tdata >> offset_bits;
    tag_shifted  = XW'(s_tdata) >> tag_shamt;
    for (int i = 0; i < SW; i++) begin
      set_mask[i] = (i < int'(eff_sb));
    end
    set_in = addr_shifted[SW-1:0] & set_mask;
  end

  logic [OP_W-1:0]      op_q;
  logic [SW-1:0]        set_q;
  logic [TAG_WIDTH-1:0] tag_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= s_tuser;
      set_q <= set_in;
      tag_q <= tag_shifted[TAG_WIDTH-1:0];
    end
  end

  // set rows; a row never written reads as empty
  logic [NUM_SETS-1:0] row_written;
  logic                row_ok_q;
  logic [ROW_W-1:0]    row_q;
  logic [ROW_W-1:0]    row_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
    end else if (cmd.commit) begin
      row_written[set_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      row_ok_q <= row_written[set_q];
    end
  end

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_q),
    .wdata (row_new),
    .re    (cmd.rd_en),
    .raddr (set_q),
    .rdata (row_q)
  );

  // lookup and lru update
  logic [MW-1:0]        vld;
  logic [RW-1:0]        rec     [MW];
  logic [TAG_WIDTH-1:0] tg      [MW];
  logic [MW-1:0]        in_use;
  logic [4:0]           eff_ways;
  logic                 hit_any;
  logic [WW-1:0]        hit_idx;
  logic                 empty_any;
  logic [WW-1:0]        empty_idx;
  logic [WW-1:0]        victim;
  logic [RW-1:0]        best_rec;
  logic [WW-1:0]        tw;
  logic                 was_valid;
  logic [RW-1:0]        old_rec;
  logic [OUTCOME_W-1:0] outcome;

  always_comb begin
    if (ways_in_use == '0) begin
      eff_ways = 5'd1;
    end else if (5'(ways_in_use) > 5'(MW)) begin
      eff_ways = 5'(MW);
    end else begin
      eff_ways = 5'(ways_in_use);
    end
    for (int v = 0; v < MW; v++) begin
      in_use[v] = (5'(v) < eff_ways);
      vld[v]    = row_ok_q & row_q[v];
      rec[v]    = row_ok_q ? row_q[REC_OFS + v * RW +: RW] : '0;
      tg[v]     = row_q[TAG_OFS + v * TAG_WIDTH +: TAG_WIDTH];
    end

    hit_any   = 1'b0;
    hit_idx   = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    for (int v = 0; v < MW; v++) begin
      if (in_use[v] && vld[v] && tg[v] == tag_q && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = WW'(v);
      end
      if (in_use[v] && !vld[v] && !empty_any) begin
        empty_any = 1'b1;
        empty_idx = WW'(v);
      end
    end

    // oldest way, ties to the lowest index
    victim   = '0;
    best_rec = rec[0];
    for (int v = 1; v < MW; v++) begin
      if (in_use[v] && rec[v] > best_rec) begin
        victim   = WW'(v);
        best_rec = rec[v];
      end
    end

    if (hit_any) begin
      tw      = hit_idx;
      outcome = OUTCOME_HIT;
    end else if (empty_any) begin
      tw      = empty_idx;
      outcome = OUTCOME_FILL;
    end else begin
      tw      = victim;
      outcome = OUTCOME_EVICT;
    end
    was_valid = vld[tw];
    old_rec   = rec[tw];

    row_new = row_q;
    for (int v = 0; v < MW; v++) begin
      row_new[v] = vld[v];
      row_new[REC_OFS + v * RW +: RW] = rec[v];
      if (WW'(v) == tw) begin
        row_new[v] = 1'b1;
        row_new[REC_OFS + v * RW +: RW] = '0;
        row_new[TAG_OFS + v * TAG_WIDTH +: TAG_WIDTH] = tag_q;
      end else if (in_use[v] && vld[v] && (!was_valid || rec[v] < old_rec)
                   && rec[v] < REC_MAX) begin
        row_new[REC_OFS + v * RW +: RW] = rec[v] + RW'(1);
      end
    end
  end

  // totals
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] eviction_count;
  logic [CNT_W-1:0] hit_count_next;
  logic [CNT_W-1:0] miss_count_next;
  logic [CNT_W-1:0] eviction_count_next;

  always_comb begin
    hit_count_next      = hit_count;
    miss_count_next     = miss_count;
    eviction_count_next = eviction_count;
    if (hit_any) begin
      if (hit_count != CNT_MAX) hit_count_next = hit_count + CNT_W'(1);
    end else begin
      if (miss_count != CNT_MAX) miss_count_next = miss_count + CNT_W'(1);
      if (!empty_any && eviction_count != CNT_MAX) begin
        eviction_count_next = eviction_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else if (cmd.commit) begin
      hit_count      <= hit_count_next;
      miss_count     <= miss_count_next;
      eviction_count <= eviction_count_next;
    end
  end

  // result register
  logic [OUTCOME_W-1:0] out_outcome;
  logic                 out_last;
  logic [CNT_W-1:0]     out_hit;
  logic [CNT_W-1:0]     out_miss;
  logic [CNT_W-1:0]     out_evict;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome <= outcome;
      out_last    <= cmd.last;
      out_hit     <= hit_count_next;
      out_miss    <= miss_count_next;
      out_evict   <= eviction_count_next;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_evict, out_miss, out_hit, out_outcome};
  assign m_tlast = out_last;

  assign stat.modify   = (op_q == OP_MODIFY);
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

### hdl/set_assoc_lru_cache_lookup.sv
// Tag-only set-associative cache lookup with lru replacement and hit/miss/eviction totals.
// Input stream: one beat per access, tuser the access kind, tdata the 48-bit byte address.
// Output stream: one result beat per lookup; a modify access gives two beats, the second
// with tlast set, loads and stores one beat with tlast set. Each beat carries the outcome
// and the saturating running totals taken after that lookup.
// Config channel: cfg_index selects set bits, offset bits or ways in use; write it only
// while the block is idle. It is always ready.
// Timing: an access is accepted, its set row is read from the row ram in the next cycle,
// and the lookup and write-back follow once the output register is free; the result beat
// is registered. Each lookup is one ram read plus one ram write-back, so a load or store
// passes through the accept, read and lookup steps and a modify runs read and lookup twice.
// The next access is accepted while the previous result still waits in the output register.
// When the receiver stalls, a finished lookup holds in the lookup step until the output
// register frees up; nothing is dropped.
// Reset (synchronous, rst high) empties the cache at once through per-set valid flags,
// clears the totals and restores set bits 0, offset bits 0 and one way in use.
module set_assoc_lru_cache_lookup import salc_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int TAG_WIDTH    = DEF_TAG_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // address
  input  logic [OP_W-1:0]       s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // outcome, hit_total, miss_total, eviction_total
  output logic                  m_tlast
);

  salc_cmd_t  cmd;
  salc_stat_t stat;

  assign cfg_ready = 1'b1;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .TAG_WIDTH    (TAG_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

### tb/sv/cache_lookup_check.sv
// channel monitor: predicts cache lookup results and compares every result beat
`timescale 1ns / 1ps

module cache_lookup_check import salc_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int TAG_WIDTH    = DEF_TAG_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // address
  input  logic [OP_W-1:0]       s_tuser,   // op
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // outcome, hit_total, miss_total, eviction_total
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    results_due
);

  localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int HIT_LSB   = OUTCOME_W;
  localparam int MISS_LSB  = HIT_LSB + CNT_W;
  localparam int EVICT_LSB = MISS_LSB + CNT_W;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 last;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     evictions;
  } lookup_result_t;

  bit                 line_ok  [NUM_LINES];
  bit [TAG_WIDTH-1:0] line_tag [NUM_LINES];
  bit [AGE_W-1:0]     line_age [NUM_LINES];
  bit [CNT_W-1:0]     hits;
  bit [CNT_W-1:0]     misses;
  bit [CNT_W-1:0]     evictions;

  bit [SET_BITS_W-1:0] set_bits;
  bit [OFFSET_W-1:0]   offset_bits;
  bit [WAYS_CFG_W-1:0] ways_cfg;

  lookup_result_t results_owed[$];
  int mismatches = 0;
  int owed_now   = 0;

  assign fail_count  = mismatches;
  assign results_due = owed_now;

  function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // the touched way becomes newest; valid ways younger than it (all valid ways if it was empty) age by one
  function automatic void refresh_age(int base, int ways, int w);
    bit was_valid;
    int old_rank;
    int v;
    was_valid = line_ok[base + w];
    old_rank  = line_age[base + w];
    for (v = 0; v < ways; v++) begin
      if (v != w && line_ok[base + v]) begin
        if (!was_valid || line_age[base + v] < old_rank) begin
          if (line_age[base + v] < MAX_WAYS - 1) line_age[base + v]++;
        end
      end
    end
    line_age[base + w] = '0;
  endfunction

  function automatic logic [OUTCOME_W-1:0] lookup_set(int set_idx, bit [TAG_WIDTH-1:0] tag);
    int ways;
    int base;
    int w;
    int victim;
    if (ways_cfg == 0) ways = 1;
    else if (ways_cfg > MAX_WAYS) ways = MAX_WAYS;
    else ways = ways_cfg;
    base = set_idx * MAX_WAYS;
    for (w = 0; w < ways; w++) begin
      if (line_ok[base + w] && line_tag[base + w] == tag) begin
        hits = sat_inc(hits);
        refresh_age(base, ways, w);
        return OUTCOME_HIT;
      end
    end
    misses = sat_inc(misses);
    for (w = 0; w < ways; w++) begin
      if (!line_ok[base + w]) begin
        refresh_age(base, ways, w);
        line_ok[base + w]  = 1'b1;
        line_tag[base + w] = tag;
        return OUTCOME_FILL;
      end
    end
    evictions = sat_inc(evictions);
    victim = 0;
    for (w = 1; w < ways; w++) begin
      if (line_age[base + w] > line_age[base + victim]) victim = w;
    end
    refresh_age(base, ways, victim);
    line_tag[base + victim] = tag;
    return OUTCOME_EVICT;
  endfunction

  function automatic void push_result(logic [OUTCOME_W-1:0] outcome, logic last);
    lookup_result_t r;
    r.outcome   = outcome;
    r.last      = last;
    r.hits      = hits;
    r.misses    = misses;
    r.evictions = evictions;
    results_owed.push_back(r);
  endfunction

  function automatic void predict_access(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    int sb;
    int set_idx;
    logic [63:0] above;
    sb      = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
    set_idx = int'((64'(addr) >> offset_bits) & ((64'd1 << sb) - 64'd1));
    above   = 64'(addr) >> (sb + offset_bits);
    // a modify looks the same tag up twice
    if (op == OP_MODIFY) push_result(lookup_set(set_idx, above[TAG_WIDTH-1:0]), 1'b0);
    push_result(lookup_set(set_idx, above[TAG_WIDTH-1:0]), 1'b1);
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < NUM_LINES; i++) begin
        line_ok[i]  = 1'b0;
        line_tag[i] = '0;
        line_age[i] = '0;
      end
      hits        = '0;
      misses      = '0;
      evictions   = '0;
      set_bits    = '0;
      offset_bits = '0;
      ways_cfg    = WAYS_CFG_W'(1);
      results_owed.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_owed.size() == 0) begin
          $error("result beat with nothing pending: tdata %h tlast %b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = results_owed.pop_front();
          check_field("outcome", CNT_W'(want.outcome), CNT_W'(m_tdata[OUTCOME_W-1:0]));
          check_field("last", CNT_W'(want.last), CNT_W'(m_tlast));
          check_field("hit_total", want.hits, m_tdata[HIT_LSB +: CNT_W]);
          check_field("miss_total", want.misses, m_tdata[MISS_LSB +: CNT_W]);
          check_field("eviction_total", want.evictions, m_tdata[EVICT_LSB +: CNT_W]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits    = cfg_data[SET_BITS_W-1:0];
          CFG_OFFSET_BITS: offset_bits = cfg_data[OFFSET_W-1:0];
          CFG_WAYS:        ways_cfg    = cfg_data[WAYS_CFG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_access(s_tuser, s_tdata);
    end
    owed_now <= results_owed.size();
  end

endmodule

### tb/sv/set_assoc_lru_cache_lookup_test.sv
// top of the cache lookup testbench: clock, reset, access stimulus and verdict
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_test;
  import salc_pkg::*;

  localparam logic [OP_W-1:0]      OP_LOAD       = 2'd0;
  localparam logic [OP_W-1:0]      OP_STORE      = 2'd1;
  localparam logic [OP_W-1:0]      OP_LOAD_ALIAS = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 102;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_MAX    = 12;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [ADDR_W-1:0]     s_tdata   = '0;
  logic [OP_W-1:0]       s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  int fail_count;
  int results_due;

  int gap_max      = 0;
  int stall_max    = 0;
  bit hold_request = 1'b0;

  // address pools of the current phase
  logic [31:0] tag_pool [POOL_MAX];
  int          set_pool [3];
  int          tag_count = 1;
  int          eff_sb    = 0;
  int          eff_off   = 0;
  int          eff_ways  = 1;

  always #2 clk = ~clk;

  set_assoc_lru_cache_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  cache_lookup_check u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // stop offering and wait until every predicted result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic set_config(input int sb_data, input int off_data, input int ways_data);
    logic [CFG_IDX_W-1:0] idx [4];
    int                   val [4];
    int                   k;
    drain();
    idx = '{CFG_SPARE, CFG_SET_BITS, CFG_OFFSET_BITS, CFG_WAYS};
    val = '{$urandom_range(0, 31), sb_data, off_data, ways_data};
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= CFG_DATA_W'(val[k]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    eff_sb   = (sb_data % 8 > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb_data % 8;
    eff_off  = off_data % 32;
    eff_ways = (ways_data % 16 == 0) ? 1 : (ways_data % 16 > DEF_MAX_WAYS) ? DEF_MAX_WAYS
                                                                           : ways_data % 16;
  endtask

  // tag from the pool, set from a few chosen sets, random byte offset
  function automatic logic [ADDR_W-1:0] make_address();
    logic [63:0] a;
    int          sh;
    sh = eff_sb + eff_off;
    a  = (64'(tag_pool[$urandom_range(0, tag_count - 1)]) << sh)
       | (64'(set_pool[$urandom_range(0, 2)]) << eff_off)
       | (64'($urandom) & ((64'd1 << eff_off) - 64'd1));
    // bits above the kept tag width must not change the lookup
    if ($urandom_range(0, 3) == 0) a = a | ({$urandom, $urandom} << (sh + 32));
    if ($urandom_range(0, 9) == 0) a = {$urandom, $urandom};
    return a[ADDR_W-1:0];
  endfunction

  // receiver: random stall per beat, one long hold-off on request
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = hold_request ? HOLD_CYCLES : $urandom_range(0, stall_max);
      hold_request = 1'b0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin
    int ph;
    int n;
    int sb_data;
    int off_data;
    int ways_data;
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one set, one way, tag is the low 32 bits of the address
    gap_max   = 16;
    stall_max = 16;
    send_access(OP_LOAD, '0);
    send_access(OP_LOAD, '0);
    send_access(OP_STORE, '1);
    send_access(OP_MODIFY, 48'h8000_0000_0001);
    send_access(OP_LOAD_ALIAS, 48'h0000_0000_0001);

    // set bits beyond the maximum, ways beyond the built count: fill set 5, then evict
    set_config(7, 4, 15);
    for (n = 1; n <= 9; n++) send_access(OP_LOAD, (ADDR_W'(n) << 10) | 48'h50);
    send_access(OP_STORE, (ADDR_W'(2) << 10) | 48'h50);
    // shrink to two ways, then zero ways (acts as one)
    set_config(7, 4, 2);
    send_access(OP_LOAD, (ADDR_W'(6) << 10) | 48'h50);
    send_access(OP_MODIFY, (ADDR_W'(3) << 10) | 48'h50);
    set_config(7, 4, 0);
    send_access(OP_MODIFY, (ADDR_W'(4) << 10) | 48'h50);
    // grown back: lines beyond the shrunk ways kept their tags
    set_config(7, 4, 8);
    send_access(OP_LOAD, (ADDR_W'(7) << 10) | 48'h50);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin sb_data = 6; off_data = 16; ways_data = 8; end
        1: begin sb_data = 0; off_data = 0; ways_data = 1; end
        2: begin sb_data = 7; off_data = 31; ways_data = 15; end
        default: begin
          sb_data = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
          pick = $urandom_range(0, 7);
          off_data = (pick < 6) ? $urandom_range(0, 6) : (pick == 6) ? 16 : $urandom_range(0, 31);
          ways_data = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        end
      endcase
      set_config(sb_data, off_data, ways_data);
      gap_max   = $urandom_range(0, 1) * 16;
      stall_max = $urandom_range(0, 1) * 16;
      if (ph == 4) begin
        // back-to-back offers against a stalled output
        gap_max      = 0;
        hold_request = 1'b1;
      end
      tag_count = eff_ways + $urandom_range(0, 3);
      for (n = 0; n < POOL_MAX; n++) begin
        tag_pool[n] = (ph % 2 == 0) ? 32'($urandom_range(0, 15)) : $urandom;
      end
      for (n = 0; n < 3; n++) set_pool[n] = int'($urandom & ((32'd1 << eff_sb) - 32'd1));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_access(OP_W'($urandom_range(0, 3)), make_address());
      end
    end

    drain();
    if (fail_count == 0 && results_due == 0) begin
      $display("set_assoc_lru_cache_lookup_test: clean");
    end else begin
      $display("set_assoc_lru_cache_lookup_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("set_assoc_lru_cache_lookup_test: errors");
    $finish;
  end

endmodule

### set_assoc_lru_cache_lookup.f
hdl/salc_pkg.sv
hdl/salc_ram.sv
hdl/salc_ctrl.sv
hdl/salc_dp.sv
hdl/set_assoc_lru_cache_lookup.sv
tb/sv/cache_lookup_check.sv
tb/sv/set_assoc_lru_cache_lookup_test.sv
